[design/tped_pkg.sv]
// Shared constants, types and helper functions of the tone prediction error detector.
// Used by the channel interfaces and by all modules of the block except tped_ram.
package tped_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int COEF_W            = 16;
  localparam int WLOG_W            = 4;
  localparam int ERR_W             = 36;
  localparam int SUM_W             = 44;
  localparam int IDX_W             = 12;
  localparam int MAX_WINDOW_LOG2   = 8;
  localparam int LINE_DEPTH        = 1 << MAX_WINDOW_LOG2;
  localparam int LINE_AW           = $clog2(LINE_DEPTH);
  localparam int WCNT_W            = LINE_AW + 1;
  localparam int MAX_RECORD_LENGTH = 4096;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
  localparam int APB_AW            = 5;
  localparam int APB_DW            = 64;
  localparam int REG_IDX_W         = 2;
  localparam int PROD_W            = 2 * COEF_W;
  localparam int ABS_W             = 32;
  localparam int ERR_SHIFT         = 28;

  localparam logic [REG_IDX_W-1:0] REG_COEF   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 2'd2;

  localparam logic [WLOG_W-1:0] WLOG_RESET = 4'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] prev2;
    logic [IDX_W-1:0]           index;
    logic                       start;
  } tped_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [WLOG_W-1:0]        wlog;
    logic [ERR_W-1:0]         threshold;
  } tped_cfg_t;

  function automatic logic [WLOG_W-1:0] eff_wlog(input logic [WLOG_W-1:0] raw);
    logic [WLOG_W-1:0] res;
    if (raw == '0) begin
      res = WLOG_W'(1);
    end else if (raw > WLOG_W'(MAX_WINDOW_LOG2)) begin
      res = WLOG_W'(MAX_WINDOW_LOG2);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

[design/tped_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on tped_pkg for field widths.
interface tped_in_if import tped_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       record_start;

  modport source(output valid, sample, record_start, input ready);
  modport sink(input valid, sample, record_start, output ready);
endinterface

interface tped_out_if import tped_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ERR_W-1:0] error_squared;
  logic [ERR_W-1:0] window_mean;
  logic             mean_valid;
  logic             above_threshold;
  logic [IDX_W-1:0] first_run_end;
  logic [IDX_W-1:0] second_run_end;
  logic             search_done;

  modport source(output valid, error_squared, window_mean, mean_valid, above_threshold,
                 first_run_end, second_run_end, search_done, input ready);
  modport sink(input valid, error_squared, window_mean, mean_valid, above_threshold,
               first_run_end, second_run_end, search_done, output ready);
endinterface

[design/tped_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module tped_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/tped_front.sv]
// Front end: accepts sample transfers, handles record starts and keeps the sample history.
// Depends on tped_pkg and tped_in_if; feeds tped_queue.
module tped_front import tped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tped_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       q_push,
  output tped_item_t q_item
);

  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt, prev2_r, prev2_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic signed [SAMPLE_W-1:0] prev_b, prev2_b;
  logic [IDX_W-1:0]           idx_b;

  always_comb begin
    in_ch.ready = !q_full;
    q_push      = in_ch.valid && !q_full;
    prev_b      = in_ch.record_start ? '0 : prev_r;
    prev2_b     = in_ch.record_start ? '0 : prev2_r;
    idx_b       = in_ch.record_start ? '0 : idx_r;
    q_item      = '{sample: in_ch.sample, prev: prev_b, prev2: prev2_b,
                    index: idx_b, start: in_ch.record_start};
    prev_nxt    = prev_r;
    prev2_nxt   = prev2_r;
    idx_nxt     = idx_r;
    if (q_push) begin
      prev2_nxt = prev_b;
      prev_nxt  = in_ch.sample;
      idx_nxt   = (idx_b == IDX_W'(MAX_RECORD_LENGTH - 1)) ? idx_b : idx_b + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      prev2_r <= '0;
      idx_r   <= '0;
    end else begin
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[design/tped_queue.sv]
// Short FIFO of sample items between the front end and the back end.
// Depends on tped_pkg for the item type.
module tped_queue import tped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tped_item_t push_item,
  output logic       full,
  input  logic       pop,
  output tped_item_t pop_item,
  output logic       empty
);

  tped_item_t          mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    full      = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    empty     = (count_r == '0);
    pop_item  = mem_r[rptr_r];
    wptr_nxt  = push ? wptr_r + QUEUE_AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + QUEUE_AW'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

[design/tped_back.sv]
// Back end: prediction error, squaring, windowed sum over the error delay line, threshold
// search and the output register. Depends on tped_pkg, tped_ram and tped_out_if.
module tped_back import tped_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tped_cfg_t  cfg,
  input  logic       sweep_start,
  input  logic       q_empty,
  input  tped_item_t q_item,
  output logic       q_pop,
  tped_out_if.source out_ch
);

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic MODE_RUN   = 1'b0;
  localparam logic MODE_SWEEP = 1'b1;

  logic                    adv, fire4;
  logic [WCNT_W-1:0]       w;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [PROD_W-1:0] p1_r;
  logic signed [SAMPLE_W:0] s1_r;
  logic [IDX_W-1:0]        idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic                    start1_r, start2_r, start3_r, start4_r, start5_r;
  logic [ABS_W-1:0]        ae2_r;
  logic [ERR_W-1:0]        sq3_r, sq4_r, sq5_r;
  logic [ERR_W-1:0]        mean5_r;
  logic                    gt5_r, lt5_r, mv5_r;

  logic signed [PROD_W:0]  e_full, e_abs;
  logic [2*ABS_W-1:0]      prod;
  logic [SUM_W-1:0]        sum_sh;

  logic                    mode_r, mode_nxt;
  logic [WCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    acc_en_r, acc_en_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt, sum_base;
  logic [LINE_AW-1:0]      wp_r, wp_nxt, rd_addr;
  logic [WCNT_W-1:0]       fill_r, fill_nxt;
  logic [ERR_W-1:0]        rd_data, leave;

  logic                    out_v_r;
  logic [ERR_W-1:0]        err_r, mean_r;
  logic                    mvalid_r, above_r;
  logic [1:0]              phase_r, phase_nxt;
  logic [IDX_W-1:0]        first_r, first_nxt, second_r, second_nxt;

  tped_ram #(.WIDTH(ERR_W), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (fire4),
    .waddr (wp_r),
    .wdata (sq3_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    w      = WCNT_W'(1) << cfg.wlog;
    adv    = !out_v_r || out_ch.ready;
    q_pop  = adv && (mode_r == MODE_RUN) && !q_empty;
    fire4  = adv && v3_r;
    e_full = ((PROD_W + 1)'(s1_r) <<< 14) - (PROD_W + 1)'(p1_r);
    e_abs  = e_full[PROD_W] ? -e_full : e_full;
    prod   = ae2_r * ae2_r;
    sum_sh = sum_r >> cfg.wlog;
  end

  // Running window sum, delay line pointers and the window re-sum pass.
  always_comb begin
    wp_nxt     = fire4 ? wp_r + LINE_AW'(1) : wp_r;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    acc_en_nxt = 1'b0;
    sum_base   = start3_r ? '0 : sum_r;
    leave      = (!start3_r && (fill_r >= w)) ? rd_data : '0;
    if ((mode_r == MODE_SWEEP) && (cnt_r < w)) begin
      rd_addr = wp_r - LINE_AW'(1) - cnt_r[LINE_AW-1:0];
    end else begin
      rd_addr = wp_nxt - w[LINE_AW-1:0];
    end
    if (sweep_start) begin
      mode_nxt = MODE_SWEEP;
      cnt_nxt  = '0;
      sum_nxt  = '0;
    end else if (mode_r == MODE_SWEEP) begin
      if (acc_en_r) begin
        sum_nxt = sum_r + SUM_W'(rd_data);
      end
      acc_en_nxt = (cnt_r < w) && (cnt_r < fill_r);
      if (cnt_r == w) begin
        mode_nxt = MODE_RUN;
      end else begin
        cnt_nxt = cnt_r + WCNT_W'(1);
      end
    end else if (fire4) begin
      sum_nxt = sum_base + SUM_W'(sq3_r) - SUM_W'(leave);
      if (start3_r) begin
        fill_nxt = WCNT_W'(1);
      end else if (fill_r != WCNT_W'(LINE_DEPTH)) begin
        fill_nxt = fill_r + WCNT_W'(1);
      end
    end
  end

  // Run search over the window mean.
  always_comb begin
    phase_nxt  = start5_r ? PH_WAIT : phase_r;
    first_nxt  = start5_r ? '0 : first_r;
    second_nxt = start5_r ? '0 : second_r;
    if ((phase_nxt == PH_WAIT) && (idx5_r >= IDX_W'(w))) begin
      phase_nxt = PH_FIRST;
    end
    unique case (phase_nxt)
      PH_FIRST: begin
        if (gt5_r) begin
          first_nxt = idx5_r;
        end else if (lt5_r) begin
          second_nxt = idx5_r;
          phase_nxt  = PH_SECOND;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SECOND: begin
        if (lt5_r) begin
          second_nxt = idx5_r;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      out_v_r  <= 1'b0;
      mode_r   <= MODE_RUN;
      cnt_r    <= '0;
      acc_en_r <= 1'b0;
      sum_r    <= '0;
      wp_r     <= '0;
      fill_r   <= '0;
      phase_r  <= PH_WAIT;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      acc_en_r <= acc_en_nxt;
      sum_r    <= sum_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      if (adv) begin
        v1_r    <= q_pop;
        v2_r    <= v1_r;
        v3_r    <= v2_r;
        v4_r    <= v3_r;
        v5_r    <= v4_r;
        out_v_r <= v5_r;
        if (v5_r) begin
          phase_r  <= phase_nxt;
          first_r  <= first_nxt;
          second_r <= second_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r     <= q_item.prev * cfg.coef;
      s1_r     <= (SAMPLE_W + 1)'(q_item.sample) + (SAMPLE_W + 1)'(q_item.prev2);
      idx1_r   <= q_item.index;
      start1_r <= q_item.start;
      ae2_r    <= e_abs[ABS_W-1:0];
      idx2_r   <= idx1_r;
      start2_r <= start1_r;
      sq3_r    <= (idx2_r < IDX_W'(2)) ? '0 : prod[ERR_SHIFT +: ERR_W];
      idx3_r   <= idx2_r;
      start3_r <= start2_r;
      sq4_r    <= sq3_r;
      idx4_r   <= idx3_r;
      start4_r <= start3_r;
      sq5_r    <= sq4_r;
      mean5_r  <= sum_sh[ERR_W-1:0];
      gt5_r    <= sum_sh[ERR_W-1:0] > cfg.threshold;
      lt5_r    <= sum_sh[ERR_W-1:0] < cfg.threshold;
      mv5_r    <= idx4_r >= IDX_W'(w - WCNT_W'(1));
      idx5_r   <= idx4_r;
      start5_r <= start4_r;
      err_r    <= sq5_r;
      mean_r   <= mean5_r;
      mvalid_r <= mv5_r;
      above_r  <= gt5_r;
    end
  end

  always_comb begin
    out_ch.valid           = out_v_r;
    out_ch.error_squared   = err_r;
    out_ch.window_mean     = mean_r;
    out_ch.mean_valid      = mvalid_r;
    out_ch.above_threshold = above_r;
    out_ch.first_run_end   = first_r;
    out_ch.second_run_end  = second_r;
    out_ch.search_done     = (phase_r == PH_DONE);
  end

endmodule

[design/tone_prediction_error_detector.sv]
// One item per cycle while out_ch.ready allows it and no re-sum pass is running.
// Per item, the window sum takes one add and one subtract against the delay line.
// A write of window_log2 starts a re-sum pass over the delay line, during which queued items
// wait. Reset (rst_n low, synchronous) resets the control registers, history and search.
// Top level: configuration registers and the front end, queue and back end.
// Depends on tped_pkg, tped_if, tped_front, tped_queue and tped_back.
module tone_prediction_error_detector import tped_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tped_in_if.sink           in_ch,
  tped_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic [WLOG_W-1:0]        wlog_r, wlog_nxt;
  logic [ERR_W-1:0]         thr_r, thr_nxt;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     wr_en, sweep_start;
  tped_cfg_t                cfg;

  logic       q_full, q_push, q_pop, q_empty;
  tped_item_t push_item, pop_item;

  always_comb begin
    pready      = 1'b1;
    reg_idx     = paddr[APB_AW-1:3];
    wr_en       = psel && penable && pwrite;
    coef_nxt    = coef_r;
    wlog_nxt    = wlog_r;
    thr_nxt     = thr_r;
    sweep_start = 1'b0;
    prdata      = '0;
    unique case (reg_idx)
      REG_COEF:   prdata = APB_DW'(unsigned'(coef_r));
      REG_WINDOW: prdata = APB_DW'(wlog_r);
      REG_THRESH: prdata = APB_DW'(thr_r);
      default:    prdata = '0;
    endcase
    if (wr_en) begin
      unique case (reg_idx)
        REG_COEF:   coef_nxt = pwdata[COEF_W-1:0];
        REG_WINDOW: begin
          wlog_nxt    = pwdata[WLOG_W-1:0];
          sweep_start = 1'b1;
        end
        REG_THRESH: thr_nxt = pwdata[ERR_W-1:0];
        default: begin
        end
      endcase
    end
    cfg = '{coef: coef_r, wlog: eff_wlog(wlog_r), threshold: thr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      wlog_r <= WLOG_RESET;
      thr_r  <= '0;
    end else begin
      coef_r <= coef_nxt;
      wlog_r <= wlog_nxt;
      thr_r  <= thr_nxt;
    end
  end

  tped_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  tped_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  tped_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .sweep_start (sweep_start),
    .q_empty     (q_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

[design/tped_checker.sv]
// Port-level assertions for the tone prediction error detector, bound to the top level.
// Depends on tped_pkg for field widths.
module tped_checker import tped_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ERR_W-1:0] out_error_squared,
  input logic [ERR_W-1:0] out_window_mean,
  input logic             pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_squared)
                                && $stable(out_window_mean))
    else $error("Result changed or dropped before its transfer.");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_squared <= 36'h4_0000_0000)
    else $error("Squared error exceeds its largest possible value.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid directly after reset.");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("Configuration port not ready.");

endmodule

bind tone_prediction_error_detector tped_checker u_tped_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_error_squared (out_ch.error_squared),
  .out_window_mean   (out_ch.window_mean),
  .pready            (pready)
);

[tb/tone_prediction_error_detector_test.sv]
// Testbench for the tone prediction error detector: drives samples and register writes,
// predicts every result in its own model of the block and checks each result transfer.
// Depends on tped_pkg, the tped_in_if/tped_out_if channel interfaces and the block itself.
`timescale 1ns / 1ps

module tone_prediction_error_detector_test import tped_pkg::*;;

  localparam int IDLE_PERCENT  = 23;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_NOISE   = 8;
  localparam int RANDOM_PASSES = 4;
  localparam int PASS_SAMPLES  = 64;
  localparam int LONG_RECORD   = 100;

  typedef enum logic [1:0] {
    SEARCH_WAIT,
    SEARCH_FIRST,
    SEARCH_SECOND,
    SEARCH_DONE
  } search_state_t;

  typedef struct {
    logic [ERR_W-1:0] error_squared;
    logic [ERR_W-1:0] window_mean;
    logic             mean_valid;
    logic             above_threshold;
    logic [IDX_W-1:0] first_run_end;
    logic [IDX_W-1:0] second_run_end;
    logic             search_done;
  } detection_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tped_in_if  in_ch();
  tped_out_if out_ch();

  tone_prediction_error_detector i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [COEF_W-1:0]   cfg_coef;
  logic [WLOG_W-1:0]          cfg_wlog;
  logic [ERR_W-1:0]           cfg_threshold;
  logic signed [SAMPLE_W-1:0] hist_x1;
  logic signed [SAMPLE_W-1:0] hist_x2;
  logic [IDX_W-1:0]           rec_index;
  logic [ERR_W-1:0]           err_line [LINE_DEPTH];
  search_state_t              search_state;
  logic [IDX_W-1:0]           first_end;
  logic [IDX_W-1:0]           second_end;

  detection_t awaited_detections[$];

  bit          idling_on = 1'b1;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          samples_sent = 0;
  int          records_sent = 0;
  int          reg_writes = 0;
  int          done_results = 0;
  int unsigned peak_run_end = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_history();
    hist_x1 = '0;
    hist_x2 = '0;
    rec_index = '0;
    foreach (err_line[i]) err_line[i] = '0;
    search_state = SEARCH_WAIT;
    first_end = '0;
    second_end = '0;
  endfunction

  function automatic int unsigned window_shift();
    int unsigned k;
    k = cfg_wlog;
    if (k < 1) k = 1;
    if (k > MAX_WINDOW_LOG2) k = MAX_WINDOW_LOG2;
    return k;
  endfunction

  function automatic detection_t compute_detection(logic signed [SAMPLE_W-1:0] x, logic start);
    detection_t       r;
    int unsigned      k;
    int               w;
    int               i;
    longint           e;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] idx;
    if (start) clear_history();
    k = window_shift();
    w = 1 << k;
    idx = rec_index;
    r.error_squared = '0;
    if (idx >= 2) begin
      e = (longint'(x) <<< 14) + (longint'(hist_x2) <<< 14)
          - longint'(cfg_coef) * longint'(hist_x1);
      r.error_squared = ERR_W'((e * e) >>> ERR_SHIFT);
    end
    for (i = LINE_DEPTH - 1; i > 0; i--) err_line[i] = err_line[i - 1];
    err_line[0] = r.error_squared;
    sum = '0;
    for (i = 0; i < w; i++) sum += SUM_W'(err_line[i]);
    r.window_mean = ERR_W'(sum >> k);
    r.mean_valid = (int'(idx) + 1 >= w);
    r.above_threshold = (r.window_mean > cfg_threshold);
    if (search_state == SEARCH_WAIT && int'(idx) >= w) search_state = SEARCH_FIRST;
    case (search_state)
      SEARCH_FIRST: begin
        if (r.window_mean > cfg_threshold) begin
          first_end = idx;
        end else if (r.window_mean < cfg_threshold) begin
          second_end = idx;
          search_state = SEARCH_SECOND;
        end else begin
          search_state = SEARCH_DONE;
        end
      end
      SEARCH_SECOND: begin
        if (r.window_mean < cfg_threshold) begin
          second_end = idx;
        end else begin
          search_state = SEARCH_DONE;
        end
      end
      default: begin
      end
    endcase
    hist_x2 = hist_x1;
    hist_x1 = x;
    if (rec_index < IDX_W'(MAX_RECORD_LENGTH - 1)) rec_index++;
    r.first_run_end = first_end;
    r.second_run_end = second_end;
    r.search_done = (search_state == SEARCH_DONE);
    return r;
  endfunction

  // A sample that the current coefficient predicts almost exactly, so the error stays small.
  function automatic logic signed [SAMPLE_W-1:0] tone_sample();
    longint v;
    v = ((longint'(cfg_coef) * longint'(hist_x1)) >>> 14) - longint'(hist_x2)
        + longint'($urandom_range(2 * QUIET_NOISE)) - QUIET_NOISE;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  function automatic void check_field(string name, logic [63:0] expv, logic [63:0] actv);
    if (expv !== actv) begin
      mismatch_count++;
      $display("%0t: %s mismatch on result %0d: expected 0x%0h, actual 0x%0h",
               $time, name, results_checked, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    detection_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_detections.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with no expected result pending", $time);
      end else begin
        want = awaited_detections.pop_front();
        check_field("error_squared", want.error_squared, out_ch.error_squared);
        check_field("window_mean", want.window_mean, out_ch.window_mean);
        check_field("mean_valid", want.mean_valid, out_ch.mean_valid);
        check_field("above_threshold", want.above_threshold, out_ch.above_threshold);
        check_field("first_run_end", want.first_run_end, out_ch.first_run_end);
        check_field("second_run_end", want.second_run_end, out_ch.second_run_end);
        check_field("search_done", want.search_done, out_ch.search_done);
        results_checked++;
        if (out_ch.search_done === 1'b1) done_results++;
        if (out_ch.first_run_end > peak_run_end) peak_run_end = out_ch.first_run_end;
      end
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic start);
    while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.record_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_detections.push_back(compute_detection(s, start));
    samples_sent++;
    if (start) records_sent++;
  endtask

  task automatic send_record(int vals[$]);
    foreach (vals[i]) send_sample(SAMPLE_W'(vals[i]), i == 0);
  endtask

  task automatic send_run(int count, bit quiet, bit start_first, bit allow_restart);
    logic signed [SAMPLE_W-1:0] s;
    bit                         st;
    for (int i = 0; i < count; i++) begin
      s = quiet ? tone_sample() : SAMPLE_W'($urandom);
      st = (i == 0 && start_first) || (allow_restart && $urandom_range(99) == 0);
      send_sample(s, st);
    end
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] reg_idx, logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({reg_idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_COEF:   cfg_coef = value[COEF_W-1:0];
      REG_WINDOW: cfg_wlog = value[WLOG_W-1:0];
      REG_THRESH: cfg_threshold = value[ERR_W-1:0];
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (awaited_detections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Samples straight after reset count as a fresh record even without a record start.
  task automatic test_power_on_record();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    settle_block();
  endtask

  // With a zero coefficient and a two-sample window the mean lands exactly on the
  // threshold, once inside the first run and once inside the second.
  task automatic test_threshold_ties();
    int pattern[$];
    apb_write(REG_COEF, '0);
    apb_write(REG_WINDOW, '0);
    apb_write(REG_THRESH, APB_DW'(8));
    pattern = '{0, 0, 4, 0, -4, 0};
    send_record(pattern);
    settle_block();
    apb_write(REG_THRESH, APB_DW'(4));
    pattern = '{0, 0, 4, 0, -4, 0, 2, 2};
    send_record(pattern);
    settle_block();
  endtask

  // Largest error, widest window from an out-of-range value, and settings changed
  // in the middle of a record.
  task automatic test_field_extremes();
    int pattern[$];
    apb_write(REG_COEF, APB_DW'(16'h8000));
    apb_write(REG_WINDOW, APB_DW'(4'hF));
    apb_write(REG_THRESH, APB_DW'({ERR_W{1'b1}}));
    pattern = '{-32768, -32768, -32768, 32767};
    send_record(pattern);
    settle_block();
    apb_write(REG_COEF, APB_DW'(16'h7FFF));
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    settle_block();
    apb_write(REG_WINDOW, APB_DW'(2));
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    settle_block();
  endtask

  // Records shaped as a noisy burst followed by a well-predicted tone, so that the
  // search walks through both runs, mixed with plain noise and broken records.
  task automatic test_random_records();
    int          first_sample;
    int          seg;
    int          kind;
    logic [63:0] thr;
    for (int p = 0; p < RANDOM_PASSES; p++) begin
      apb_write(REG_COEF, APB_DW'(16'($urandom)));
      apb_write(REG_WINDOW, ($urandom_range(3) == 0) ? APB_DW'($urandom_range(15))
                                                     : APB_DW'($urandom_range(4, 1)));
      case ($urandom_range(5))
        0:       thr = '0;
        1:       thr = {$urandom, $urandom} & {{(64 - ERR_W){1'b0}}, {ERR_W{1'b1}}};
        default: thr = 64'($urandom_range(1 << 30));
      endcase
      apb_write(REG_THRESH, thr);
      first_sample = samples_sent;
      while (samples_sent - first_sample < PASS_SAMPLES) begin
        seg = (1 << window_shift());
        if (seg > 48) seg = 48;
        kind = $urandom_range(9);
        if (kind <= 6) begin
          send_run(seg + $urandom_range(16, 1), 1'b0, 1'b1, 1'b1);
          send_run(seg + $urandom_range(24, 1), 1'b1, 1'b0, 1'b1);
          if ($urandom_range(1)) send_run($urandom_range(12, 1), 1'b0, 1'b0, 1'b1);
        end else if (kind == 7) begin
          send_run($urandom_range(40, 4), 1'b0, 1'b1, 1'b1);
        end else if (kind == 8) begin
          send_run($urandom_range(30, 4), 1'b1, 1'b0, 1'b1);
        end else begin
          send_run($urandom_range(40, 4), 1'b1, 1'b1, 1'b1);
        end
      end
      settle_block();
    end
  endtask

  // The result side holds off for a long stretch while samples keep coming, then both
  // sides run without any idle cycles.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    hold_requests++;
    send_run(48, 1'b0, 1'b1, 1'b0);
    send_run(40, 1'b1, 1'b0, 1'b0);
    settle_block();
    idling_on = 1'b1;
  endtask

  // A long noisy record against a zero threshold, so the first run keeps extending.
  task automatic test_long_record();
    apb_write(REG_WINDOW, APB_DW'(3));
    apb_write(REG_THRESH, '0);
    send_run(LONG_RECORD, 1'b0, 1'b1, 1'b0);
    settle_block();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.record_start <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_coef = '0;
    cfg_wlog = WLOG_RESET;
    cfg_threshold = '0;
    clear_history();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_record();
    test_threshold_ties();
    test_field_extremes();
    test_random_records();
    test_output_backpressure();
    test_long_record();

    $display("Covered %0d samples in %0d records over %0d register writes; %0d results checked.",
             samples_sent, records_sent, reg_writes, results_checked);
    $display("Search finished in %0d results; highest first run end seen was %0d.",
             done_results, peak_run_end);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("Timeout with %0d results still expected", awaited_detections.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
